### sv/gmv_pkg.sv
// ----------------------------------------------------------------------------
// gmv_pkg
// Shared types and constants for the 3x3 matrix times vector unit.
// ----------------------------------------------------------------------------
package gmv_pkg;

   // field widths
   localparam int unsigned VEC_W   = 32;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned ROW_W   = 3 * COEF_W;
   localparam int unsigned TRANS_W = 32;
   localparam int unsigned RES_W   = 32;
   localparam int unsigned FRAC_W  = 12;

   // datapath widths
   localparam int unsigned PROD_W  = COEF_W + VEC_W;         // one entry times one component
   localparam int unsigned TSH_W   = TRANS_W + FRAC_W;       // translation times 4096
   localparam int unsigned PAIR_W  = PROD_W + 1;             // sum of two terms
   localparam int unsigned SUM_W   = PROD_W + 2;             // full row sum
   localparam int unsigned SHR_W   = SUM_W - FRAC_W;         // after floor shift

   // register index port
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_ROW_0 = 3'd0,
      CSR_ROT_ROW_1 = 3'd1,
      CSR_ROT_ROW_2 = 3'd2,
      CSR_TRANS_X   = 3'd3,
      CSR_TRANS_Y   = 3'd4,
      CSR_TRANS_Z   = 3'd5
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = ROW_W;

   // number of register stages in the datapath
   localparam int unsigned NUM_STAGES = 4;

   // input word
   typedef struct packed {
      logic                     kind;
      logic signed [VEC_W-1:0]  vec_x;
      logic signed [VEC_W-1:0]  vec_y;
      logic signed [VEC_W-1:0]  vec_z;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [RES_W-1:0]  res_0;
      logic signed [RES_W-1:0]  res_1;
      logic signed [RES_W-1:0]  res_2;
   } rsp_type;

   // per-stage load enables, from pipeline control to the row datapaths
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctrl_type;

endpackage

### sv/gte_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// gte_matrix_vector_multiply
// 3x3 fixed-point matrix times vector unit with optional translation.
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes the matrix rows (index 0..2, three signed 16-bit entries,
//   column 0 in low bits) and translation x/y/z (index 3..5). csr_ready is
//   always high; writes to other indexes are dropped. Write only while idle.
//   req_* carries one word per item: mode bit and a signed 32-bit vector.
//   rsp_* returns one word per item: three row results, in order.
// Stages: multiply, pair sums, row sum and shift/saturate, each ending in a
//   register, with the last stage being the output register.
// One word per cycle unless stalled; each row has its own three multipliers.
// Reset: clears all stage valid bits and all configuration registers.
// Stall: a full stage holds when the next one cannot take its word, so
//   bubbles are squeezed out; req_stall rises only when stage one is full
//   and cannot move forward. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gte_matrix_vector_multiply (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gmv_pkg::req_type                    req_word,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gmv_pkg::rsp_type                    rsp_word,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gmv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gmv_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [gmv_pkg::NUM_STAGES-1:0] valid_ff, valid_in;
   logic [gmv_pkg::NUM_STAGES-1:0] advance;
   gmv_pkg::stage_ctrl_type        ctrl;

   logic [gmv_pkg::ROW_W-1:0]          rot_row_0_ff, rot_row_1_ff, rot_row_2_ff;
   logic signed [gmv_pkg::TRANS_W-1:0] trans_x_ff, trans_y_ff, trans_z_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_0_ff <= '0;
         rot_row_1_ff <= '0;
         rot_row_2_ff <= '0;
         trans_x_ff   <= '0;
         trans_y_ff   <= '0;
         trans_z_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (gmv_pkg::csr_index_type'(csr_index))
            gmv_pkg::CSR_ROT_ROW_0: rot_row_0_ff <= csr_data;
            gmv_pkg::CSR_ROT_ROW_1: rot_row_1_ff <= csr_data;
            gmv_pkg::CSR_ROT_ROW_2: rot_row_2_ff <= csr_data;
            gmv_pkg::CSR_TRANS_X:   trans_x_ff   <= csr_data[gmv_pkg::TRANS_W-1:0];
            gmv_pkg::CSR_TRANS_Y:   trans_y_ff   <= csr_data[gmv_pkg::TRANS_W-1:0];
            gmv_pkg::CSR_TRANS_Z:   trans_z_ff   <= csr_data[gmv_pkg::TRANS_W-1:0];
            default: ;
         endcase
      end
   end

   // stage advance: a stage loads when it is empty or its word moves on
   always_comb begin
      advance[gmv_pkg::NUM_STAGES-1] = !valid_ff[gmv_pkg::NUM_STAGES-1] || !rsp_stall;
      for (int i = gmv_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign req_stall = !advance[0];
   assign ctrl.load = advance;

   // valid bits travel with the words
   always_comb begin
      valid_in = valid_ff;
      if (advance[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < gmv_pkg::NUM_STAGES; i++) begin
         if (advance[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one datapath per row
   gmv_row u_row_0 (
      .clock   (clock),
      .ctrl    (ctrl),
      .rot_row (rot_row_0_ff),
      .trans   (trans_x_ff),
      .req     (req_word),
      .result  (rsp_word.res_0)
   );

   gmv_row u_row_1 (
      .clock   (clock),
      .ctrl    (ctrl),
      .rot_row (rot_row_1_ff),
      .trans   (trans_y_ff),
      .req     (req_word),
      .result  (rsp_word.res_1)
   );

   gmv_row u_row_2 (
      .clock   (clock),
      .ctrl    (ctrl),
      .rot_row (rot_row_2_ff),
      .trans   (trans_z_ff),
      .req     (req_word),
      .result  (rsp_word.res_2)
   );

   assign rsp_valid = valid_ff[gmv_pkg::NUM_STAGES-1];

endmodule

### sv/gmv_row.sv
// ----------------------------------------------------------------------------
// gmv_row
// Four-stage datapath for one matrix row: multiply, pair sums, row sum,
// floor shift with saturate or wrap.
// ----------------------------------------------------------------------------
module gmv_row (
   input  logic                                  clock,
   input  gmv_pkg::stage_ctrl_type               ctrl,
   input  logic [gmv_pkg::ROW_W-1:0]             rot_row,
   input  logic signed [gmv_pkg::TRANS_W-1:0]    trans,
   input  gmv_pkg::req_type                      req,
   output logic signed [gmv_pkg::RES_W-1:0]      result
);

   localparam logic signed [gmv_pkg::SHR_W-1:0] SAT_MAX = gmv_pkg::SHR_W'(32767);
   localparam logic signed [gmv_pkg::SHR_W-1:0] SAT_MIN = -(gmv_pkg::SHR_W'(32768));

   logic signed [gmv_pkg::COEF_W-1:0] coef_0, coef_1, coef_2;

   logic signed [gmv_pkg::PROD_W-1:0] prod_0_ff, prod_0_in;
   logic signed [gmv_pkg::PROD_W-1:0] prod_1_ff, prod_1_in;
   logic signed [gmv_pkg::PROD_W-1:0] prod_2_ff, prod_2_in;
   logic signed [gmv_pkg::TSH_W-1:0]  tsh_ff, tsh_in;
   logic                              kind_1_ff;

   logic signed [gmv_pkg::PAIR_W-1:0] pair_a_ff, pair_a_in;
   logic signed [gmv_pkg::PAIR_W-1:0] pair_b_ff, pair_b_in;
   logic                              kind_2_ff;

   logic signed [gmv_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                              kind_3_ff;

   logic signed [gmv_pkg::SHR_W-1:0]  shr;
   logic signed [gmv_pkg::RES_W-1:0]  result_ff, result_in;

   // matrix entries, column 0 in low bits
   assign coef_0 = $signed(rot_row[gmv_pkg::COEF_W-1:0]);
   assign coef_1 = $signed(rot_row[2*gmv_pkg::COEF_W-1:gmv_pkg::COEF_W]);
   assign coef_2 = $signed(rot_row[3*gmv_pkg::COEF_W-1:2*gmv_pkg::COEF_W]);

   // stage 1: products and scaled translation
   always_comb begin
      prod_0_in = gmv_pkg::PROD_W'(coef_0 * req.vec_x);
      prod_1_in = gmv_pkg::PROD_W'(coef_1 * req.vec_y);
      prod_2_in = gmv_pkg::PROD_W'(coef_2 * req.vec_z);
      if (req.kind) begin
         tsh_in = {trans, {gmv_pkg::FRAC_W{1'b0}}};
      end else begin
         tsh_in = '0;
      end
   end

   // stage 2: two pair sums
   assign pair_a_in = gmv_pkg::PAIR_W'(prod_0_ff) + gmv_pkg::PAIR_W'(prod_1_ff);
   assign pair_b_in = gmv_pkg::PAIR_W'(prod_2_ff) + gmv_pkg::PAIR_W'(tsh_ff);

   // stage 3: full row sum
   assign sum_in = gmv_pkg::SUM_W'(pair_a_ff) + gmv_pkg::SUM_W'(pair_b_ff);

   // stage 4: floor shift, then saturate to 16 bits or wrap to 32 bits
   assign shr = gmv_pkg::SHR_W'(sum_ff >>> gmv_pkg::FRAC_W);

   always_comb begin
      if (kind_3_ff) begin
         result_in = shr[gmv_pkg::RES_W-1:0];
      end else if (shr > SAT_MAX) begin
         result_in = gmv_pkg::RES_W'(SAT_MAX);
      end else if (shr < SAT_MIN) begin
         result_in = gmv_pkg::RES_W'(SAT_MIN);
      end else begin
         result_in = shr[gmv_pkg::RES_W-1:0];
      end
   end

   // payload registers, loaded by pipeline control
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_0_ff <= prod_0_in;
         prod_1_ff <= prod_1_in;
         prod_2_ff <= prod_2_in;
         tsh_ff    <= tsh_in;
         kind_1_ff <= req.kind;
      end
      if (ctrl.load[1]) begin
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
         kind_2_ff <= kind_1_ff;
      end
      if (ctrl.load[2]) begin
         sum_ff    <= sum_in;
         kind_3_ff <= kind_2_ff;
      end
      if (ctrl.load[3]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### tb/sv/gte_matrix_vector_multiply_tb.sv
// ----------------------------------------------------------------------------
// gte_matrix_vector_multiply_tb
// Self-checking bench for the 3x3 matrix times vector unit. The matrix rows
// and translation are loaded over the register port while the pipe is empty,
// and each accepted vector word is run through a local 64-bit model of the
// row sums. Results are compared field by field, in order. Both channels
// idle and stall at random, with some phases running back to back.
// ----------------------------------------------------------------------------
module gte_matrix_vector_multiply_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CLOCK_HALF   = 4;
   localparam int  CYCLE_LIMIT  = 500000;
   localparam int  RANDOM_PHASES = 8;
   localparam int  PHASE_WORDS  = 125;
   localparam int  MAX_WAIT     = 13;

   // mode bit of an input word
   localparam logic MODE_SATURATE  = 1'b0;
   localparam logic MODE_TRANSLATE = 1'b1;

   // register indexes past the end of the map, writes must be dropped
   localparam logic [gmv_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [gmv_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // -------------------------------------------------------------------------
   // expected row results and the register copy they are computed from
   // -------------------------------------------------------------------------
   class row_result_scoreboard;
      gmv_pkg::rsp_type                   expected_rows_q[$];
      logic [gmv_pkg::ROW_W-1:0]          matrix_rows[3];
      logic signed [gmv_pkg::TRANS_W-1:0] offsets[3];
      int                                 errors;

      function new();
         errors = 0;
         for (int r = 0; r < 3; r++) begin
            matrix_rows[r] = '0;
            offsets[r]     = '0;
         end
      endfunction

      // mirror of a register write, unmapped indexes are ignored
      function void set_register(logic [gmv_pkg::CSR_IDX_W-1:0] index,
                                 logic [gmv_pkg::CSR_DATA_W-1:0] data);
         case (index)
            gmv_pkg::CSR_ROT_ROW_0: matrix_rows[0] = data[gmv_pkg::ROW_W-1:0];
            gmv_pkg::CSR_ROT_ROW_1: matrix_rows[1] = data[gmv_pkg::ROW_W-1:0];
            gmv_pkg::CSR_ROT_ROW_2: matrix_rows[2] = data[gmv_pkg::ROW_W-1:0];
            gmv_pkg::CSR_TRANS_X:   offsets[0] = data[gmv_pkg::TRANS_W-1:0];
            gmv_pkg::CSR_TRANS_Y:   offsets[1] = data[gmv_pkg::TRANS_W-1:0];
            gmv_pkg::CSR_TRANS_Z:   offsets[2] = data[gmv_pkg::TRANS_W-1:0];
            default: ;
         endcase
      endfunction

      // row sums, floor shift by the fraction width, then saturate or wrap
      function gmv_pkg::rsp_type transform_vector(gmv_pkg::req_type word);
         longint  comp[3];
         longint  acc;
         longint  shifted;
         logic [gmv_pkg::RES_W-1:0] row_out[3];
         gmv_pkg::rsp_type result;
         comp[0] = longint'(word.vec_x);
         comp[1] = longint'(word.vec_y);
         comp[2] = longint'(word.vec_z);
         for (int r = 0; r < 3; r++) begin
            acc = 0;
            if (word.kind == MODE_TRANSLATE)
               acc = longint'(offsets[r]) * (longint'(1) << gmv_pkg::FRAC_W);
            for (int c = 0; c < 3; c++)
               acc += longint'($signed(matrix_rows[r][gmv_pkg::COEF_W*c +: gmv_pkg::COEF_W]))
                      * comp[c];
            shifted = acc >>> gmv_pkg::FRAC_W;
            if (word.kind == MODE_SATURATE) begin
               if (shifted > 32767)
                  shifted = 32767;
               else if (shifted < -32768)
                  shifted = -32768;
            end
            row_out[r] = shifted[gmv_pkg::RES_W-1:0];
         end
         result.res_0 = row_out[0];
         result.res_1 = row_out[1];
         result.res_2 = row_out[2];
         return result;
      endfunction

      function void note_request(gmv_pkg::req_type word);
         expected_rows_q.push_back(transform_vector(word));
      endfunction

      function void compare_field(string label, logic [gmv_pkg::RES_W-1:0] want,
                                  logic [gmv_pkg::RES_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_result(gmv_pkg::rsp_type word);
         gmv_pkg::rsp_type want;
         if (expected_rows_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, word);
            errors++;
         end else begin
            want = expected_rows_q.pop_front();
            compare_field("res_0", want.res_0, word.res_0);
            compare_field("res_1", want.res_1, word.res_1);
            compare_field("res_2", want.res_2, word.res_2);
         end
      endfunction

      function int pending();
         return expected_rows_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block hookup
   // -------------------------------------------------------------------------
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   gmv_pkg::req_type               req_word  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   gmv_pkg::rsp_type               rsp_word;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [gmv_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gmv_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   row_result_scoreboard board = new();
   bit steady = 1'b0;   // no idling on either side while set
   int cycles = 0;

   gte_matrix_vector_multiply u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result monitor, samples pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_word);
   end

   // result side back pressure, one draw per result word
   initial begin
      int hold;
      forever begin
         hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [gmv_pkg::ROW_W-1:0] pack_row(logic [15:0] c0, logic [15:0] c1,
                                                          logic [15:0] c2);
      return {c2, c1, c0};
   endfunction

   function automatic logic signed [31:0] rand_component();
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6: begin
            k = $urandom_range(1, 24);
            return int'($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
         end
         7, 8: begin
            case ($urandom_range(0, 6))
               0: return S32_MAX;
               1: return S32_MIN;
               2: return 0;
               3: return -1;
               4: return 1;
               5: return 4096;
               default: return -4096;
            endcase
         end
         default: return int'($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom());
         4, 5: return 16'h1000 + 16'($urandom_range(0, 63)) - 16'd32;
         6: begin
            case ($urandom_range(0, 5))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               4: return 16'h1000;
               default: return 16'hF000;
            endcase
         end
         default: return 16'($urandom_range(0, 4095)) - 16'd2048;
      endcase
   endfunction

   // one register write, valid left high for a following write
   task automatic write_register(logic [gmv_pkg::CSR_IDX_W-1:0] index,
                                 logic [gmv_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, data);
   endtask

   // stop sending and wait for the pipe to empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (gmv_pkg::NUM_STAGES) @(posedge clock);
   endtask

   // full register load while idle, upper data bits carry noise
   task automatic load_settings(logic [gmv_pkg::ROW_W-1:0] r0, logic [gmv_pkg::ROW_W-1:0] r1,
                                logic [gmv_pkg::ROW_W-1:0] r2, logic [31:0] tx,
                                logic [31:0] ty, logic [31:0] tz);
      drain_pipeline();
      write_register(gmv_pkg::CSR_ROT_ROW_0, r0);
      write_register(gmv_pkg::CSR_ROT_ROW_1, r1);
      write_register(gmv_pkg::CSR_ROT_ROW_2, r2);
      write_register(gmv_pkg::CSR_TRANS_X, {16'($urandom()), tx});
      write_register(gmv_pkg::CSR_TRANS_Y, {16'($urandom()), ty});
      write_register(gmv_pkg::CSR_TRANS_Z, {16'($urandom()), tz});
      write_register($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                     {$urandom(), 16'($urandom())});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one vector word, valid stays high when the next gap is zero
   task automatic send_vector(logic kind, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
      gmv_pkg::req_type word;
      int gap;
      word.kind  = kind;
      word.vec_x = x;
      word.vec_y = y;
      word.vec_z = z;
      gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= word;
      do @(posedge clock); while (req_stall);
      board.note_request(word);
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix, translation at the extremes
      load_settings(pack_row(16'h1000, 16'h0000, 16'h0000),
                    pack_row(16'h0000, 16'h1000, 16'h0000),
                    pack_row(16'h0000, 16'h0000, 16'h1000),
                    S32_MAX, S32_MIN, 32'hFFFF_FFFF);
      send_vector(MODE_SATURATE,  0, 0, 0);
      send_vector(MODE_TRANSLATE, 0, 0, 0);
      send_vector(MODE_SATURATE,  S32_MAX, S32_MIN, -1);
      send_vector(MODE_TRANSLATE, S32_MAX, S32_MIN, -1);
      send_vector(MODE_SATURATE,  32767, -32768, 4095);
      send_vector(MODE_SATURATE,  32768, -32769, 1);
      send_vector(MODE_TRANSLATE, -1, 1, S32_MAX);

      // most negative entries everywhere, largest products
      load_settings(pack_row(16'h8000, 16'h8000, 16'h8000),
                    pack_row(16'h8000, 16'h8000, 16'h8000),
                    pack_row(16'h8000, 16'h8000, 16'h8000),
                    S32_MIN, S32_MIN, S32_MIN);
      send_vector(MODE_SATURATE,  S32_MIN, S32_MIN, S32_MIN);
      send_vector(MODE_TRANSLATE, S32_MIN, S32_MIN, S32_MIN);
      send_vector(MODE_SATURATE,  S32_MAX, S32_MAX, S32_MAX);
      send_vector(MODE_TRANSLATE, S32_MAX, S32_MAX, S32_MAX);
      send_vector(MODE_SATURATE,  1, 0, 0);

      // most positive entries, floor of small negative sums
      load_settings(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                    S32_MAX, S32_MAX, S32_MAX);
      send_vector(MODE_SATURATE,  S32_MAX, S32_MAX, S32_MAX);
      send_vector(MODE_TRANSLATE, S32_MAX, S32_MAX, S32_MAX);
      send_vector(MODE_SATURATE,  S32_MIN, S32_MIN, S32_MIN);
      send_vector(MODE_TRANSLATE, S32_MIN, S32_MIN, S32_MIN);
      send_vector(MODE_SATURATE,  1, 0, 0);
      send_vector(MODE_SATURATE,  -1, 0, 0);
      send_vector(MODE_TRANSLATE, -1, -1, -1);
      send_vector(MODE_TRANSLATE, 0, 0, 0);

      // random settings and vectors, some phases back to back
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_settings(pack_row(rand_coef(), rand_coef(), rand_coef()),
                       pack_row(rand_coef(), rand_coef(), rand_coef()),
                       pack_row(rand_coef(), rand_coef(), rand_coef()),
                       rand_component(), rand_component(), rand_component());
         steady = (p % 4 == 3);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // hold off mid phase until every result is back
            if (n == PHASE_WORDS / 2 && p % 2 == 0)
               drain_pipeline();
            send_vector(1'($urandom()), rand_component(), rand_component(),
                        rand_component());
         end
         steady = 1'b0;
      end

      // all words sent, wait out the pipe
      steady = 1'b1;
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4 * gmv_pkg::NUM_STAGES) @(posedge clock);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
sv/gmv_pkg.sv
sv/gmv_row.sv
sv/gte_matrix_vector_multiply.sv
tb/sv/gte_matrix_vector_multiply_tb.sv
